[src/iterative_integer_alu_top_assert.svh]
// ----------------------------------------------------------------------------
// Iterative integer ALU assertion macros
// Concurrent checks clocked on i_clk, disabled while i_rst_n is low.
// ----------------------------------------------------------------------------
`ifndef ITERATIVE_INTEGER_ALU_TOP_ASSERT_SVH
`define ITERATIVE_INTEGER_ALU_TOP_ASSERT_SVH

// same-cycle implication
`define IIA_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("iterative_integer_alu_top: same-cycle check failed");

// next-cycle implication
`define IIA_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("iterative_integer_alu_top: next-cycle check failed");

`endif

[src/iia_pkg.sv]
// ----------------------------------------------------------------------------
// iia_pkg
// Shared types and constants of the iterative integer ALU.
// ----------------------------------------------------------------------------
`default_nettype none

package iia_pkg;

    localparam int OPW         = 16;                        // operand width
    localparam int CMDW        = 3;
    localparam int RESW        = 32;
    localparam int STW         = 2;
    localparam int PRODW       = RESW + OPW;                // acc x operand
    localparam int IN_FLD_W    = CMDW + 2 * OPW;
    localparam int IN_TDATA_W  = ((IN_FLD_W + 7) / 8) * 8;
    localparam int OUT_FLD_W   = RESW + STW;
    localparam int OUT_TDATA_W = ((OUT_FLD_W + 7) / 8) * 8;

    localparam logic [RESW-1:0] POS_MAX = 32'h7FFF_FFFF;

    localparam logic [STW-1:0] ST_OK       = 2'd0;
    localparam logic [STW-1:0] ST_DIVZERO  = 2'd1;
    localparam logic [STW-1:0] ST_OVERFLOW = 2'd2;

    typedef enum logic [CMDW-1:0] {
        CMD_ADD  = 3'd0,
        CMD_SUB  = 3'd1,
        CMD_MUL  = 3'd2,
        CMD_DIV  = 3'd3,
        CMD_MOD  = 3'd4,
        CMD_POW  = 3'd5,
        CMD_FACT = 3'd6
    } t_cmd;

    typedef enum logic [2:0] {
        S_IDLE,     // waiting for a transaction
        S_MUL,      // multiplier issue
        S_CHK,      // product check and loop control
        S_DIV,      // one restoring divide step
        S_WB        // hand result to the output register
    } t_state;

endpackage

`default_nettype wire

[src/iterative_integer_alu_top.sv]
// Flow: add, subtract, zero divisor and quick power/factorial cases go from
//   idle straight to write-back; multiply makes one multiply/check pass; power
//   and factorial one pass per step (at most 31 steps); divide/modulo OPW steps.
// One transaction at a time; with the output ready the next one is accepted
//   in the cycle m_axis_tvalid rises.
// ----------------------------------------------------------------------------
// iterative_integer_alu_top
// Command ALU: add, sub, mul, div, mod, power, factorial with a shared
// multiplier and a restoring radix-2 divider under a small sequencer.
// Reset: synchronous, active low; sequencer to idle, output register empty.
// ----------------------------------------------------------------------------
`default_nettype none

`include "iterative_integer_alu_top_assert.svh"

module iterative_integer_alu_top (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    // tdata: command[2:0], operand_a[18:3], operand_b[34:19], zero pad
    input  wire logic [iia_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
    input  wire logic                            s_axis_tvalid,
    output logic                                 s_axis_tready,
    // tdata: result[31:0] (signed), status[33:32], zero pad
    output logic [iia_pkg::OUT_TDATA_W-1:0]      m_axis_tdata,
    output logic                                 m_axis_tvalid,
    input  wire logic                            m_axis_tready
);
    import iia_pkg::*;

    localparam int CNTW    = OPW;
    localparam int OUT_PAD = OUT_TDATA_W - OUT_FLD_W;

    // input field split
    logic [CMDW-1:0] w_cmd_raw;
    logic [OPW-1:0]  w_a;
    logic [OPW-1:0]  w_b;
    t_cmd            w_cmd;

    assign w_cmd_raw = s_axis_tdata[CMDW-1:0];
    assign w_a       = s_axis_tdata[CMDW+OPW-1:CMDW];
    assign w_b       = s_axis_tdata[CMDW+2*OPW-1:CMDW+OPW];
    assign w_cmd     = t_cmd'(w_cmd_raw);

    // sequencer and datapath registers
    t_state           r_state, n_state;
    logic [CMDW-1:0]  r_cmd, n_cmd;
    logic [OPW-1:0]   r_a, n_a;
    logic [OPW-1:0]   r_b, n_b;
    logic [RESW-1:0]  r_acc, n_acc;       // running product
    logic [OPW-1:0]   r_mop, n_mop;       // multiplier operand (base or k)
    logic [CNTW-1:0]  r_cnt, n_cnt;       // exponent / divide step count
    logic [PRODW-1:0] r_prod, n_prod;
    logic [OPW-1:0]   r_rem, n_rem;
    logic [OPW-1:0]   r_quo, n_quo;
    logic [RESW-1:0]  r_pres, n_pres;     // pending result
    logic [STW-1:0]   r_pst, n_pst;       // pending status
    logic [RESW-1:0]  r_res, n_res;       // output register
    logic [STW-1:0]   r_st, n_st;
    logic             r_ovalid, n_ovalid;

    logic in_xact;
    logic out_xact;
    logic wb_go;

    assign s_axis_tready = (r_state == S_IDLE);
    assign in_xact       = s_axis_tvalid && s_axis_tready;
    assign out_xact      = r_ovalid && m_axis_tready;
    assign wb_go         = (r_state == S_WB) && (!r_ovalid || m_axis_tready);

    // decode of a new transaction: which ones finish without iterating
    logic w_quick;
    always_comb begin
        unique case (w_cmd)
            CMD_MUL:          w_quick = 1'b0;
            CMD_DIV, CMD_MOD: w_quick = (w_b == '0);
            CMD_POW:          w_quick = (w_b == '0) || (w_a <= OPW'(1));
            CMD_FACT:         w_quick = (w_a <= OPW'(1));
            default:          w_quick = 1'b1;
        endcase
    end

    // product check
    logic w_ovf;
    logic w_done;
    assign w_ovf  = (r_prod > PRODW'(POS_MAX));
    assign w_done = (r_cmd == CMD_FACT) ? (r_mop == r_a) : (r_cnt == CNTW'(1));

    // restoring divide step
    logic [OPW:0] w_rsh;
    logic [OPW:0] w_diff;
    assign w_rsh  = {r_rem, r_quo[OPW-1]};
    assign w_diff = w_rsh - {1'b0, r_b};

    // ---- next state ----
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (in_xact) begin
                    if (w_quick)
                        n_state = S_WB;
                    else if (w_cmd == CMD_DIV || w_cmd == CMD_MOD)
                        n_state = S_DIV;
                    else
                        n_state = S_MUL;
                end
            end
            S_MUL: n_state = S_CHK;
            S_CHK: n_state = (w_ovf || w_done) ? S_WB : S_MUL;
            S_DIV: n_state = (r_cnt == CNTW'(1)) ? S_WB : S_DIV;
            S_WB:  n_state = wb_go ? S_IDLE : S_WB;
            default: n_state = S_IDLE;
        endcase
    end

    // ---- datapath and outputs ----
    logic [OPW:0] w_sum;
    assign w_sum = {1'b0, w_a} + {1'b0, w_b};

    always_comb begin
        n_cmd    = r_cmd;
        n_a      = r_a;
        n_b      = r_b;
        n_acc    = r_acc;
        n_mop    = r_mop;
        n_cnt    = r_cnt;
        n_prod   = r_prod;
        n_rem    = r_rem;
        n_quo    = r_quo;
        n_pres   = r_pres;
        n_pst    = r_pst;
        n_res    = r_res;
        n_st     = r_st;
        n_ovalid = r_ovalid;

        if (out_xact)
            n_ovalid = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (in_xact) begin
                    n_cmd = w_cmd_raw;
                    n_a   = w_a;
                    n_b   = w_b;
                    n_pst = ST_OK;
                    n_pres = '0;
                    unique case (w_cmd)
                        CMD_ADD: begin
                            if (RESW'(w_sum) > POS_MAX) begin
                                n_pres = POS_MAX;
                                n_pst  = ST_OVERFLOW;
                            end else begin
                                n_pres = RESW'(w_sum);
                            end
                        end
                        CMD_SUB: n_pres = RESW'(w_a) - RESW'(w_b);
                        CMD_MUL: begin
                            // single pass through the multiply loop
                            n_acc = RESW'(w_a);
                            n_mop = w_b;
                            n_cnt = CNTW'(1);
                        end
                        CMD_DIV, CMD_MOD: begin
                            if (w_b == '0) begin
                                n_pst = ST_DIVZERO;
                            end else begin
                                n_rem = '0;
                                n_quo = w_a;
                                n_cnt = CNTW'(OPW);
                            end
                        end
                        CMD_POW: begin
                            if (w_b == '0 || w_a == OPW'(1))
                                n_pres = RESW'(1);
                            else if (w_a == '0)
                                n_pres = '0;
                            n_acc = RESW'(1);
                            n_mop = w_a;
                            n_cnt = w_b;
                        end
                        CMD_FACT: begin
                            n_pres = RESW'(1);   // 0! and 1!
                            n_acc  = RESW'(1);
                            n_mop  = OPW'(2);
                        end
                        default: n_pres = '0;
                    endcase
                end
            end
            S_MUL: n_prod = PRODW'(r_acc) * PRODW'(r_mop);
            S_CHK: begin
                if (w_ovf) begin
                    n_pres = POS_MAX;
                    n_pst  = ST_OVERFLOW;
                end else begin
                    n_acc  = r_prod[RESW-1:0];
                    n_pres = r_prod[RESW-1:0];
                    n_pst  = ST_OK;
                    if (r_cmd == CMD_FACT)
                        n_mop = r_mop + OPW'(1);
                    else
                        n_cnt = r_cnt - CNTW'(1);
                end
            end
            S_DIV: begin
                if (!w_diff[OPW]) begin
                    n_rem = w_diff[OPW-1:0];
                    n_quo = {r_quo[OPW-2:0], 1'b1};
                end else begin
                    n_rem = w_rsh[OPW-1:0];
                    n_quo = {r_quo[OPW-2:0], 1'b0};
                end
                n_cnt = r_cnt - CNTW'(1);
                if (r_cnt == CNTW'(1)) begin
                    n_pst  = ST_OK;
                    n_pres = (r_cmd == CMD_MOD) ? RESW'(n_rem) : RESW'(n_quo);
                end
            end
            S_WB: begin
                if (wb_go) begin
                    n_res    = r_pres;
                    n_st     = r_pst;
                    n_ovalid = 1'b1;
                end
            end
            default: ;
        endcase
    end

    // ---- registers ----
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd  <= n_cmd;
        r_a    <= n_a;
        r_b    <= n_b;
        r_acc  <= n_acc;
        r_mop  <= n_mop;
        r_cnt  <= n_cnt;
        r_prod <= n_prod;
        r_rem  <= n_rem;
        r_quo  <= n_quo;
        r_pres <= n_pres;
        r_pst  <= n_pst;
        r_res  <= n_res;
        r_st   <= n_st;
    end

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = {{OUT_PAD{1'b0}}, r_st, r_res};

    // ---- assertions ----
    `IIA_ASSERT_NOW(a_divzero_zero, r_ovalid && r_st == ST_DIVZERO, r_res == '0)
    `IIA_ASSERT_NOW(a_ovf_sat, r_ovalid && r_st == ST_OVERFLOW, r_res == POS_MAX)
    `IIA_ASSERT_NOW(a_acc_in_range, r_state == S_MUL, !r_acc[RESW-1])
    `IIA_ASSERT_NOW(a_div_cnt, r_state == S_DIV, r_cnt != '0 && r_cnt <= CNTW'(OPW))
    `IIA_ASSERT_NEXT(a_busy_after_in, in_xact, r_state != S_IDLE)

endmodule

`default_nettype wire

[tb/sv/iterative_integer_alu_top_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iterative_integer_alu_top_tb
// Self-checking bench for the command ALU. A directed table covers operand
// extremes, every command, zero divisors, saturation and the unused command;
// random commands follow under three idle mixes and one long output stall.
// Each output transaction is compared with a queued prediction.
// ----------------------------------------------------------------------------
module iterative_integer_alu_top_tb;
    import iia_pkg::*;

    localparam logic [CMDW-1:0] CMD_UNUSED = 3'd7;   // decodes to 0 / ok
    localparam int              HOLD_CYCLES = 300;
    localparam int              DRAIN_CYCLES = 70;   // margin after the queue empties
    localparam int              ITEMS_PER_PHASE = 160;

    typedef struct {
        logic [RESW-1:0] result;
        logic [STW-1:0]  status;
    } t_alu_result;

    typedef struct {
        logic [CMDW-1:0] cmd;
        logic [OPW-1:0]  a;
        logic [OPW-1:0]  b;
        bit              typed;     // expected value given in the row
        logic [RESW-1:0] result;
        logic [STW-1:0]  status;
    } t_alu_row;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    // tdata: command[2:0], operand_a[18:3], operand_b[34:19], zero pad
    logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    // tdata: result[31:0] (signed), status[33:32], zero pad
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;

    t_alu_result pending_results[$];
    int          error_count = 0;
    int          send_idle_pct = 36;
    int          recv_idle_pct = 86;
    logic        hold_req = 1'b0;
    logic        hold_taken = 1'b0;
    int          hold_left = 0;

    t_alu_row directed_rows[] = '{
        '{CMD_ADD,  16'd0,     16'd0,     1'b1, 32'd0,          ST_OK},
        '{CMD_ADD,  16'd65535, 16'd65535, 1'b1, 32'd131070,     ST_OK},
        '{CMD_SUB,  16'd0,     16'd65535, 1'b1, 32'hFFFF_0001,  ST_OK},
        '{CMD_SUB,  16'd65535, 16'd0,     1'b1, 32'd65535,      ST_OK},
        '{CMD_MUL,  16'd65535, 16'd65535, 1'b1, POS_MAX,        ST_OVERFLOW},
        '{CMD_MUL,  16'd46340, 16'd46340, 1'b0, 32'd0,          ST_OK},
        '{CMD_MUL,  16'd46341, 16'd46341, 1'b0, 32'd0,          ST_OK},
        '{CMD_DIV,  16'd1234,  16'd0,     1'b1, 32'd0,          ST_DIVZERO},
        '{CMD_DIV,  16'd0,     16'd0,     1'b1, 32'd0,          ST_DIVZERO},
        '{CMD_DIV,  16'd65535, 16'd1,     1'b1, 32'd65535,      ST_OK},
        '{CMD_MOD,  16'd77,    16'd0,     1'b1, 32'd0,          ST_DIVZERO},
        '{CMD_MOD,  16'd0,     16'd0,     1'b1, 32'd0,          ST_DIVZERO},
        '{CMD_MOD,  16'd5,     16'd9,     1'b1, 32'd5,          ST_OK},
        '{CMD_MOD,  16'd65535, 16'd65535, 1'b0, 32'd0,          ST_OK},
        '{CMD_POW,  16'd0,     16'd0,     1'b1, 32'd1,          ST_OK},
        '{CMD_POW,  16'd65535, 16'd0,     1'b1, 32'd1,          ST_OK},
        '{CMD_POW,  16'd0,     16'd5,     1'b1, 32'd0,          ST_OK},
        '{CMD_POW,  16'd1,     16'd65535, 1'b1, 32'd1,          ST_OK},
        '{CMD_POW,  16'd2,     16'd30,    1'b0, 32'd0,          ST_OK},
        '{CMD_POW,  16'd2,     16'd31,    1'b1, POS_MAX,        ST_OVERFLOW},
        '{CMD_POW,  16'd65535, 16'd65535, 1'b1, POS_MAX,        ST_OVERFLOW},
        '{CMD_FACT, 16'd0,     16'd65535, 1'b1, 32'd1,          ST_OK},
        '{CMD_FACT, 16'd12,    16'd0,     1'b0, 32'd0,          ST_OK},
        '{CMD_FACT, 16'd13,    16'd0,     1'b1, POS_MAX,        ST_OVERFLOW},
        '{CMD_UNUSED, 16'd65535, 16'd65535, 1'b1, 32'd0,        ST_OK}
    };

    iterative_integer_alu_top DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready)
    );

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    // Hard stop well past the slowest legal run.
    initial begin
        #10_000_000;
        $display("simulation failed");
        $finish;
    end

    // Anything above the signed 32-bit maximum saturates with overflow status.
    function automatic t_alu_result clamp_to_max(input logic [63:0] value);
        t_alu_result r;
        if (value > {32'd0, POS_MAX}) begin
            r.result = POS_MAX;
            r.status = ST_OVERFLOW;
        end else begin
            r.result = value[RESW-1:0];
            r.status = ST_OK;
        end
        return r;
    endfunction

    function automatic t_alu_result predict_alu(input logic [CMDW-1:0] cmd,
                                                input logic [OPW-1:0] a,
                                                input logic [OPW-1:0] b);
        t_alu_result r;
        logic [63:0] acc;
        logic [63:0] wa;
        logic [63:0] wb;
        int unsigned k;
        wa = {{(64-OPW){1'b0}}, a};
        wb = {{(64-OPW){1'b0}}, b};
        r.result = '0;
        r.status = ST_OK;
        case (cmd)
            CMD_ADD: r = clamp_to_max(wa + wb);
            CMD_SUB: r.result = wa[RESW-1:0] - wb[RESW-1:0];   // wraps negative
            CMD_MUL: r = clamp_to_max(wa * wb);
            CMD_DIV, CMD_MOD: begin
                if (b == '0)
                    r.status = ST_DIVZERO;
                else if (cmd == CMD_DIV)
                    r.result = RESW'(wa / wb);
                else
                    r.result = RESW'(wa % wb);
            end
            CMD_POW: begin
                if (b == '0 || a == 1)
                    r.result = 32'd1;
                else if (a != '0) begin
                    // base >= 2 overflows within 31 steps, loop exits early
                    acc = 64'd1;
                    for (k = 0; k < b && r.status == ST_OK; k++) begin
                        acc = acc * wa;
                        r = clamp_to_max(acc);
                    end
                end
            end
            CMD_FACT: begin
                acc = 64'd1;
                r.result = 32'd1;
                for (k = 2; k <= a && r.status == ST_OK; k++) begin
                    acc = acc * k;
                    r = clamp_to_max(acc);
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    // Offer one command; the expectation is queued at the accepting edge.
    task automatic send_command(input t_alu_row row);
        logic [IN_TDATA_W-1:0] word;
        t_alu_result           expected;
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        word = '0;
        word[CMDW-1:0] = row.cmd;
        word[CMDW +: OPW] = row.a;
        word[CMDW+OPW +: OPW] = row.b;
        s_axis_tdata  <= word;
        s_axis_tvalid <= 1'b1;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        if (row.typed) begin
            expected.result = row.result;
            expected.status = row.status;
        end else begin
            expected = predict_alu(row.cmd, row.a, row.b);
        end
        pending_results.push_back(expected);
    endtask

    function automatic logic [OPW-1:0] random_operand();
        case ($urandom_range(3))
            0:       return OPW'($urandom_range(65535));
            1:       return OPW'($urandom_range(15));
            2:       return OPW'($urandom_range(255));
            default: begin
                case ($urandom_range(3))
                    0:       return '0;
                    1:       return OPW'(1);
                    2:       return '1;
                    default: return '1 - 1'b1;
                endcase
            end
        endcase
    endfunction

    // Output side: random backpressure, plus one long hold-off on request.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
            hold_left     <= 0;
            hold_taken    <= 1'b0;
        end else if (hold_req && !hold_taken) begin
            hold_taken    <= 1'b1;
            hold_left     <= HOLD_CYCLES;
            m_axis_tready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left     <= hold_left - 1;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Result checker: every output transaction must match the oldest prediction.
    always @(posedge i_clk) begin
        t_alu_result want;
        logic [RESW-1:0] got_result;
        logic [STW-1:0]  got_status;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got_result = m_axis_tdata[RESW-1:0];
            got_status = m_axis_tdata[RESW +: STW];
            if (pending_results.size() == 0) begin
                $error("unexpected result transaction: result=%0d status=%0d",
                       $signed(got_result), got_status);
                error_count++;
            end else begin
                want = pending_results.pop_front();
                if (got_result !== want.result) begin
                    $error("result mismatch: expected %0d, got %0d",
                           $signed(want.result), $signed(got_result));
                    error_count++;
                end
                if (got_status !== want.status) begin
                    $error("status mismatch: expected %0d, got %0d",
                           want.status, got_status);
                    error_count++;
                end
            end
        end
    end

    initial begin
        t_alu_row row;
        int       phase;
        int       n;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed_rows[i])
            send_command(directed_rows[i]);

        for (phase = 0; phase < 3; phase++) begin
            case (phase)
                0: begin
                    send_idle_pct <= 36;
                    recv_idle_pct <= 86;
                end
                1: begin
                    send_idle_pct <= 86;
                    recv_idle_pct <= 36;
                end
                default: begin
                    // no idling; the long output stall makes the input back up
                    send_idle_pct <= 0;
                    recv_idle_pct <= 0;
                    hold_req      <= 1'b1;
                end
            endcase
            for (n = 0; n < ITEMS_PER_PHASE; n++) begin
                row.cmd   = CMDW'($urandom_range(7));
                row.a     = random_operand();
                row.b     = random_operand();
                row.typed = 1'b0;
                // keep power and factorial mostly below saturation
                if (row.cmd == CMD_POW && $urandom_range(1)) begin
                    row.a = OPW'($urandom_range(20));
                    row.b = OPW'($urandom_range(31));
                end else if (row.cmd == CMD_FACT && $urandom_range(3) != 0) begin
                    row.a = OPW'($urandom_range(14));
                end
                send_command(row);
            end
        end
        s_axis_tvalid <= 1'b0;

        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (error_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

[filelist.f]
+incdir+src
src/iia_pkg.sv
src/iterative_integer_alu_top.sv
tb/sv/iterative_integer_alu_top_tb.sv
